[rtl/dfiir_pkg.sv]
`default_nettype none
package dfiir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int TAPCNT_W   = 5;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 4;
  localparam int IN_DATA_W  = 40;

  localparam logic REG_FWD_TAPS = 1'b0;
  localparam logic REG_FB_TAPS  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_LOAD_FWD = 2'd1,
    CMD_LOAD_FB  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic clear;
    logic valid;
    logic neg;
  } mac_ctl_t;

endpackage
`default_nettype wire

[rtl/dfiir_ram.sv]
`default_nettype none
module dfiir_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/dfiir_mac.sv]
`default_nettype none
module dfiir_mac #(
  parameter int ACC_W = 41
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dfiir_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [dfiir_pkg::COEF_W-1:0]    coef_i,
  input  logic signed [dfiir_pkg::SAMPLE_W-1:0]  hist_i,
  output logic signed [ACC_W-1:0]                acc_o,
  output logic                                   busy_o
);
  import dfiir_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     p_valid_q;
  logic                     p_neg_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_neg_q   <= 1'b0;
    end else begin
      p_valid_q <= ctl_i.valid;
      p_neg_q   <= ctl_i.neg;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * hist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (p_valid_q) begin
      acc_q <= p_neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = p_valid_q;

endmodule
`default_nettype wire

[rtl/direct_form_iir_filter_core.sv]
// Direct-form I IIR filter with one shared multiply-accumulate.
// Input stream: tuser carries the command (sample, load forward coefficient,
// load feedback coefficient); tdata carries coefficient slot, Q4.14
// coefficient and Q1.15 sample; tlast marks the final sample of a signal.
// Load items give no output item; tready stays high. A sample item takes
// MAX_FORWARD_TAPS + MAX_FEEDBACK_TAPS steps through the shared multiplier,
// one coefficient slot per step (feedback slot zero is skipped, the final
// step is empty), then drains its stage-one and product registers into the
// accumulator. tready stays low until the result is in the output register;
// no new item is taken while a sample is in progress. Output stream: tdata is
// the rounded, saturated sample, tuser the saturation flag, tlast a copy of
// the input tlast. After a tlast sample both histories clear. A finished
// sample waits in the output register; a stalled receiver holds the block in
// its drain state once the next sample is done. The user must write tap counts
// on the config port while the block is idle; the block does not enforce it.
// Reset clears tap counts to one, coefficients (via valid bits) and history.
`default_nettype none
module direct_form_iir_filter_core #(
  parameter int MAX_FORWARD_TAPS  = 16,
  parameter int MAX_FEEDBACK_TAPS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [dfiir_pkg::TAPCNT_W-1:0]         cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // coef_index [3:0], coef_value [21:4], sample_in [37:22], zero [39:38]
  input  logic [dfiir_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // cmd [1:0]
  input  logic [dfiir_pkg::CMD_W-1:0]            s_axis_tuser,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // sample_out [15:0]
  output logic [dfiir_pkg::SAMPLE_W-1:0]         m_axis_tdata,
  // saturated [0]
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import dfiir_pkg::*;

  localparam int TOT   = MAX_FORWARD_TAPS + MAX_FEEDBACK_TAPS;
  localparam int AW    = $clog2(TOT);
  localparam int ACC_W = PROD_W + $clog2(TOT) + 1;

  state_e                      state_q, state_d;
  logic [AW-1:0]               step_q, step_d;
  logic [TAPCNT_W-1:0]         fcnt_q, bcnt_q;
  logic [TOT-1:0]              cvalid_q;
  logic signed [SAMPLE_W-1:0]  xr_q [MAX_FORWARD_TAPS];
  logic signed [SAMPLE_W-1:0]  xr_d [MAX_FORWARD_TAPS];
  logic signed [SAMPLE_W-1:0]  yr_q [MAX_FEEDBACK_TAPS];
  logic signed [SAMPLE_W-1:0]  yr_d [MAX_FEEDBACK_TAPS];
  logic                        last_q;
  logic                        s1_valid_q, s1_use_q, s1_neg_q, s1_cv_q;
  logic                        s1_use_d;
  logic signed [SAMPLE_W-1:0]  s1_hist_q;
  logic                        out_valid_q;
  logic [SAMPLE_W-1:0]         out_data_q;
  logic                        out_last_q, out_sat_q;

  logic                        in_fire, start, fwd_phase, last_step, finish, running;
  logic [INDEX_W-1:0]          in_idx;
  logic [COEF_W-1:0]           in_coef;
  logic signed [SAMPLE_W-1:0]  in_sample;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [COEF_W-1:0]           ram_rdata;
  mac_ctl_t                    mac_ctl;
  logic signed [COEF_W-1:0]    mac_coef;
  logic signed [ACC_W-1:0]     acc;
  logic                        mac_busy;
  logic signed [ACC_W-1:0]     acc_rnd, acc_sh;
  logic                        y_sat;
  logic signed [SAMPLE_W-1:0]  y_val;

  assign in_idx    = s_axis_tdata[INDEX_W-1:0];
  assign in_coef   = s_axis_tdata[INDEX_W+COEF_W-1:INDEX_W];
  assign in_sample = s_axis_tdata[INDEX_W+COEF_W+SAMPLE_W-1:INDEX_W+COEF_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign start         = in_fire && (s_axis_tuser == CMD_SAMPLE);
  assign running       = (state_q == ST_RUN);
  assign fwd_phase     = 32'(step_q) < 32'(MAX_FORWARD_TAPS);
  assign last_step     = (step_q == AW'(TOT - 1));
  assign finish        = (state_q == ST_DRAIN) && !s1_valid_q && !mac_busy &&
                         (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= TAPCNT_W'(1);
      bcnt_q <= TAPCNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FWD_TAPS: fcnt_q <= cfg_wdata_i;
        REG_FB_TAPS:  bcnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(in_idx);
    if (in_fire && (s_axis_tuser == CMD_LOAD_FWD) &&
        (32'(in_idx) < 32'(MAX_FORWARD_TAPS))) begin
      ram_we = 1'b1;
    end else if (in_fire && (s_axis_tuser == CMD_LOAD_FB) &&
                 (32'(in_idx) < 32'(MAX_FEEDBACK_TAPS))) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(MAX_FORWARD_TAPS) + AW'(in_idx);
    end
  end

  always_comb begin
    ram_raddr = '0;
    if (running && !last_step) begin
      ram_raddr = fwd_phase ? step_q : step_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
    end else if (ram_we) begin
      cvalid_q[ram_waddr] <= 1'b1;
    end
  end

  dfiir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TOT)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_coef),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + AW'(1);
        if (last_step) begin
          state_d = ST_DRAIN;
          step_d  = '0;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (fwd_phase) begin
      s1_use_d = 32'(step_q) < 32'(fcnt_q);
    end else begin
      s1_use_d = !last_step &&
                 ((32'(step_q) - 32'(MAX_FORWARD_TAPS) + 32'd1) < 32'(bcnt_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= running;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_use_q  <= s1_use_d;
    s1_neg_q  <= !fwd_phase;
    s1_hist_q <= fwd_phase ? xr_q[0] : yr_q[0];
    s1_cv_q   <= cvalid_q[ram_raddr];
  end

  assign mac_ctl.clear = start;
  assign mac_ctl.valid = s1_valid_q;
  assign mac_ctl.neg   = s1_neg_q;
  assign mac_coef      = (s1_use_q && s1_cv_q) ? ram_rdata : '0;

  dfiir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .hist_i (s1_hist_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign acc_rnd = acc + ACC_W'(ROUND_BIAS);
  assign acc_sh  = acc_rnd >>> FRAC_SHIFT;
  assign y_sat   = !((&acc_sh[ACC_W-1:SAMPLE_W-1]) || !(|acc_sh[ACC_W-1:SAMPLE_W-1]));

  always_comb begin
    y_val = acc_sh[SAMPLE_W-1:0];
    if (y_sat) begin
      y_val = acc_sh[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_comb begin
    xr_d = xr_q;
    if (start) begin
      xr_d[0] = in_sample;
      for (int j = 1; j < MAX_FORWARD_TAPS; j++) begin
        xr_d[j] = xr_q[j-1];
      end
    end else if (running && fwd_phase) begin
      for (int j = 0; j < MAX_FORWARD_TAPS - 1; j++) begin
        xr_d[j] = xr_q[j+1];
      end
      xr_d[MAX_FORWARD_TAPS-1] = xr_q[0];
    end else if (finish && last_q) begin
      for (int j = 0; j < MAX_FORWARD_TAPS; j++) begin
        xr_d[j] = '0;
      end
    end
  end

  always_comb begin
    yr_d = yr_q;
    if (finish) begin
      if (last_q) begin
        for (int j = 0; j < MAX_FEEDBACK_TAPS; j++) begin
          yr_d[j] = '0;
        end
      end else begin
        yr_d[0] = y_val;
        for (int j = 1; j < MAX_FEEDBACK_TAPS; j++) begin
          yr_d[j] = yr_q[j-1];
        end
      end
    end else if (running && !fwd_phase) begin
      for (int j = 0; j < MAX_FEEDBACK_TAPS - 1; j++) begin
        yr_d[j] = yr_q[j+1];
      end
      yr_d[MAX_FEEDBACK_TAPS-1] = yr_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_FORWARD_TAPS; j++) begin
        xr_q[j] <= '0;
      end
      for (int j = 0; j < MAX_FEEDBACK_TAPS; j++) begin
        yr_q[j] <= '0;
      end
    end else begin
      xr_q <= xr_d;
      yr_q <= yr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= finish || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= y_val;
      out_last_q <= last_q;
      out_sat_q  <= y_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_valid_q && !mac_busy))
    else $error("multiply pipeline busy while idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running |-> (32'(step_q) < 32'(TOT)))
    else $error("step counter out of range");

  a_sample_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (xr_q[0] == $past(in_sample)))
    else $error("input sample not pushed into history");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DRAIN) && out_valid_q && !m_axis_tready) |=> (state_q == ST_DRAIN))
    else $error("result finished while output slot full");

endmodule
`default_nettype wire

[dv/direct_form_iir_filter_core_test.sv]
`default_nettype none
module direct_form_iir_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dfiir_pkg::*;

  localparam int FWD_DEPTH = 16;
  localparam int FB_DEPTH = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TAPCNT_W-1:0] PHASE_FWD [PHASES] = '{
    5'd4, 5'd16, 5'd2, 5'd31, 5'd0, 5'd9, 5'd3, 5'd1};
  localparam logic [TAPCNT_W-1:0] PHASE_FB [PHASES] = '{
    5'd3, 5'd16, 5'd16, 5'd1, 5'd5, 5'd9, 5'd17, 5'd2};

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [INDEX_W-1:0]        idx;
    logic signed [COEF_W-1:0]  coef;
    logic signed [SAMPLE_W-1:0] sample;
    logic                      last;
  } iir_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       sat;
  } iir_out_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    iir_item_t             it;
    logic                  known;
    iir_out_t              out;
    logic                  cfg_sel;
    logic [TAPCNT_W-1:0]   cfg_val;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [TAPCNT_W-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [CMD_W-1:0] s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  logic signed [COEF_W-1:0]   fwd_coef [FWD_DEPTH];
  logic signed [COEF_W-1:0]   fb_coef [FB_DEPTH];
  logic signed [SAMPLE_W-1:0] x_hist [FWD_DEPTH];
  logic signed [SAMPLE_W-1:0] y_hist [FB_DEPTH];
  logic [TAPCNT_W-1:0] fwd_taps = 5'd1;
  logic [TAPCNT_W-1:0] fb_taps = 5'd1;

  iir_out_t pending_out [$];
  iir_out_t oldest_out;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  direct_form_iir_filter_core #(
    .MAX_FORWARD_TAPS (FWD_DEPTH),
    .MAX_FEEDBACK_TAPS(FB_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic logic filter_step(input iir_item_t it, output iir_out_t res);
    longint acc;
    longint y;
    int nf;
    int na;
    int i;
    res = '0;
    if (it.cmd == CMD_LOAD_FWD) begin
      fwd_coef[it.idx] = it.coef;
      return 1'b0;
    end
    if (it.cmd == CMD_LOAD_FB) begin
      fb_coef[it.idx] = it.coef;
      return 1'b0;
    end
    if (it.cmd != CMD_SAMPLE) return 1'b0;
    nf = (fwd_taps > FWD_DEPTH) ? FWD_DEPTH : int'(fwd_taps);
    na = (fb_taps > FB_DEPTH) ? FB_DEPTH : int'(fb_taps);
    acc = 0;
    if (nf > 0) acc = longint'(fwd_coef[0]) * longint'(it.sample);
    for (i = 1; i < nf; i++) acc += longint'(fwd_coef[i]) * longint'(x_hist[i - 1]);
    for (i = 1; i < na; i++) acc -= longint'(fb_coef[i]) * longint'(y_hist[i - 1]);
    y = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
    if (y > 32767) begin
      y = 32767;
      res.sat = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      res.sat = 1'b1;
    end
    res.sample = SAMPLE_W'(y);
    res.last = it.last;
    for (i = FWD_DEPTH - 1; i > 0; i--) x_hist[i] = x_hist[i - 1];
    x_hist[0] = it.sample;
    for (i = FB_DEPTH - 1; i > 0; i--) y_hist[i] = y_hist[i - 1];
    y_hist[0] = res.sample;
    if (it.last) begin
      foreach (x_hist[k]) x_hist[k] = '0;
      foreach (y_hist[k]) y_hist[k] = '0;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t item_row(input logic [CMD_W-1:0] cmd,
                                         input logic [INDEX_W-1:0] idx,
                                         input logic [COEF_W-1:0] coef,
                                         input logic [SAMPLE_W-1:0] smp,
                                         input logic last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.it = '{cmd: cmd, idx: idx, coef: coef, sample: smp, last: last};
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [SAMPLE_W-1:0] smp, input logic last,
                                          input logic [SAMPLE_W-1:0] ys, input logic sat);
    stim_row_t r;
    r = item_row(CMD_SAMPLE, '0, '0, smp, last);
    r.known = 1'b1;
    r.out = '{sample: ys, last: last, sat: sat};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic sel, input logic [TAPCNT_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic send_item(input iir_item_t it, input logic known, input iir_out_t want);
    iir_out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it.sample, it.coef, it.idx};
    s_axis_tuser <= it.cmd;
    s_axis_tlast <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (filter_step(it, res)) pending_out.push_back(known ? want : res);
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tap_count(input logic sel, input logic [TAPCNT_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == REG_FWD_TAPS) fwd_taps = val;
    else fb_taps = val;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected output item sample=%h sat=%b last=%b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        oldest_out = pending_out.pop_front();
        if (m_axis_tdata !== oldest_out.sample) begin
          $display("%0t: sample_out expected %h actual %h", $time, oldest_out.sample,
                   m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== oldest_out.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, oldest_out.sat,
                   m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tlast !== oldest_out.last) begin
          $display("%0t: last_out expected %b actual %b", $time, oldest_out.last,
                   m_axis_tlast);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    iir_item_t it;
    int sent;
    int phase;
    int r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FWD_TAPS;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_SAMPLE;
    s_axis_tlast = 1'b0;
    foreach (fwd_coef[k]) fwd_coef[k] = '0;
    foreach (fb_coef[k]) fb_coef[k] = '0;
    foreach (x_hist[k]) x_hist[k] = '0;
    foreach (y_hist[k]) y_hist[k] = '0;

    directed.push_back(known_row(16'h7fff, 1'b0, 16'h0000, 1'b0));
    directed.push_back(known_row(16'h8000, 1'b1, 16'h0000, 1'b0));
    directed.push_back(item_row(CMD_UNUSED, 4'hf, 18'h3ffff, 16'hffff, 1'b1));
    directed.push_back(item_row(CMD_LOAD_FWD, 4'h0, 18'h04000, 16'h0000, 1'b0));
    directed.push_back(known_row(16'h7fff, 1'b0, 16'h7fff, 1'b0));
    directed.push_back(known_row(16'h8000, 1'b1, 16'h8000, 1'b0));
    directed.push_back(item_row(CMD_LOAD_FWD, 4'h0, 18'h1ffff, 16'h0000, 1'b0));
    directed.push_back(known_row(16'h7fff, 1'b0, 16'h7fff, 1'b1));
    directed.push_back(known_row(16'h8000, 1'b1, 16'h8000, 1'b1));
    directed.push_back(item_row(CMD_LOAD_FWD, 4'h0, 18'h20000, 16'h0000, 1'b0));
    directed.push_back(known_row(16'h8000, 1'b1, 16'h7fff, 1'b1));
    directed.push_back(item_row(CMD_LOAD_FWD, 4'hf, 18'h02000, 16'h0000, 1'b0));
    directed.push_back(item_row(CMD_LOAD_FWD, 4'h1, 18'h3e000, 16'h0000, 1'b0));
    directed.push_back(item_row(CMD_LOAD_FB, 4'h0, 18'h1ffff, 16'h0000, 1'b0));
    directed.push_back(item_row(CMD_LOAD_FB, 4'h1, 18'h02000, 16'h0000, 1'b0));
    directed.push_back(item_row(CMD_LOAD_FB, 4'hf, 18'h20000, 16'h0000, 1'b0));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h0001, 1'b0));
    directed.push_back(cfg_row(REG_FWD_TAPS, 5'd0));
    directed.push_back(cfg_row(REG_FB_TAPS, 5'd31));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h4000, 1'b0));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'hc000, 1'b1));
    directed.push_back(cfg_row(REG_FWD_TAPS, 5'd31));
    directed.push_back(cfg_row(REG_FB_TAPS, 5'd0));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h7fff, 1'b0));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h1234, 1'b1));
    directed.push_back(cfg_row(REG_FWD_TAPS, 5'd16));
    directed.push_back(cfg_row(REG_FB_TAPS, 5'd16));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h2000, 1'b0));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h8000, 1'b0));
    directed.push_back(item_row(CMD_SAMPLE, 4'h0, 18'h00000, 16'h7fff, 1'b1));
    directed.push_back(cfg_row(REG_FWD_TAPS, 5'd1));
    directed.push_back(cfg_row(REG_FB_TAPS, 5'd1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) begin
      if (directed[n].kind == ROW_CFG) begin
        drain_outputs();
        write_tap_count(directed[n].cfg_sel, directed[n].cfg_val);
      end else begin
        send_item(directed[n].it, directed[n].known, directed[n].out);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain_outputs();
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 77;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 77;
        end
        default: begin
          tx_idle_pct = 6;
          rx_stall_pct = 6;
        end
      endcase
      write_tap_count(REG_FWD_TAPS, (phase == 6) ? TAPCNT_W'($urandom_range(31)) :
                                                   PHASE_FWD[phase]);
      write_tap_count(REG_FB_TAPS, (phase == 6) ? TAPCNT_W'($urandom_range(31)) :
                                                  PHASE_FB[phase]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        it.cmd = (r < 62) ? CMD_SAMPLE : (r < 78) ? CMD_LOAD_FWD :
                 (r < 95) ? CMD_LOAD_FB : CMD_UNUSED;
        it.idx = INDEX_W'($urandom_range(15));
        case ($urandom_range(3))
          0: it.coef = COEF_W'($urandom);
          3: it.coef = $urandom_range(1) ? 18'h1ffff : 18'h20000;
          default: it.coef = COEF_W'($urandom_range(8191) - 4096);
        endcase
        case ($urandom_range(7))
          0: it.sample = 16'h7fff;
          1: it.sample = 16'h8000;
          2: it.sample = SAMPLE_W'($urandom_range(511) - 256);
          default: it.sample = SAMPLE_W'($urandom);
        endcase
        it.last = ($urandom_range(15) == 0);
        if ($urandom_range(99) == 0) drain_outputs();
        send_item(it, 1'b0, '0);
        if (it.cmd != CMD_UNUSED) sent++;
      end
    end

    drain_outputs();
    if (mismatch_count == 0 && pending_out.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
